// ----- rtl/core/ilir_pkg.sv -----
// Package for the indexed list block: sizes, operation and status codes.
// Used by the top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ilir_pkg;

	localparam int CAPACITY = 256;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic [1:0]  op_t;
	typedef logic [1:0]  status_t;
	typedef logic [7:0]  pos_t;
	typedef logic [63:0] word_t;
	typedef logic [8:0]  count_out_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_REMOVE = 2'd1;
	localparam op_t OP_PUSH   = 2'd2;
	localparam op_t OP_POP    = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_FULL  = 2'd2;
	localparam status_t ST_EMPTY = 2'd3;

endpackage
`default_nettype wire

// ----- rtl/core/indexed_list_insert_remove_top.sv -----
// Indexed list top level: list memory, shift sequencer and result register.
// Depends on ilir_pkg.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps an ordered list of up to CAPACITY 64-bit values in one
// single-port-write, registered-read memory. Each request does insert at an
// index, remove at an index, push or pop, and returns one result with the
// value taken, a status and the new count. Entries move one per cycle
// through the memory port. An insert at position p below the count n
// steps through S_INS, S_INSW and S_INSV, a remove or pop through S_REM
// and S_REMW, a push or an insert at the end goes straight to S_INSV, and
// a request rejected for range, full or empty goes straight to S_DONE. One
// request is worked at a time; a new request is taken the cycle after the
// previous result sits in the output register, even if it is not yet taken.
module indexed_list_insert_remove_top (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  ilir_pkg::op_t        operation,
	input  ilir_pkg::pos_t       position,
	input  ilir_pkg::word_t      value_in,
	output logic                 out_valid,
	input  wire                  out_ready,
	output ilir_pkg::word_t      value_out,
	output ilir_pkg::status_t    status,
	output ilir_pkg::count_out_t count_after
);
	import ilir_pkg::*;

	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_INSW = 3'd2;
	localparam logic [2:0] S_INSV = 3'd3;
	localparam logic [2:0] S_REM  = 3'd4;
	localparam logic [2:0] S_REMW = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic             vld_s1;

	logic [IDX_W-1:0] pos_q, ptr_q, last_q, ptr_s1;
	word_t            val_q, res_value_q, rdata_s1;
	status_t          res_status_q;

	word_t            mem [CAPACITY];

	logic             acc, rd_en, wr_en, cap_en, out_load;
	logic [IDX_W-1:0] wr_addr, cnt_m1;
	word_t            wr_data;

	status_t          dec_status;
	logic [2:0]       dec_next;
	logic [IDX_W-1:0] dec_pos, dec_ptr, dec_last;
	logic [CMP_W-1:0] cnt_ext, pos_ext;
	logic             is_full, is_empty;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign acc       = in_valid && in_ready;
	assign rd_en     = (state_q == S_INS) || (state_q == S_REM);
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign cnt_ext  = CMP_W'(count_q);
	assign pos_ext  = CMP_W'(position);
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign cnt_m1   = IDX_W'(count_q - CNT_W'(1));

	// Check the request against the current count and pick the work to do.
	always_comb begin
		dec_status = ST_OK;
		dec_next   = S_DONE;
		dec_pos    = '0;
		dec_ptr    = '0;
		dec_last   = '0;
		unique case (operation)
			OP_INSERT: begin
				dec_pos = IDX_W'(position);
				dec_ptr = cnt_m1;
				if (is_full) begin
					dec_status = ST_FULL;
				end else if (pos_ext > cnt_ext) begin
					dec_status = ST_RANGE;
				end else begin
					dec_next = (pos_ext == cnt_ext) ? S_INSV : S_INS;
				end
			end
			OP_REMOVE: begin
				dec_pos  = IDX_W'(position);
				dec_ptr  = IDX_W'(position);
				dec_last = cnt_m1;
				if (is_empty) begin
					dec_status = ST_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					dec_status = ST_RANGE;
				end else begin
					dec_next = S_REM;
				end
			end
			OP_PUSH: begin
				dec_pos = IDX_W'(count_q);
				if (is_full) begin
					dec_status = ST_FULL;
				end else begin
					dec_next = S_INSV;
				end
			end
			OP_POP: begin
				dec_pos  = cnt_m1;
				dec_ptr  = cnt_m1;
				dec_last = cnt_m1;
				if (is_empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_next = S_REM;
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	// Write port. Insert walks reads downward and writes one above the
	// read; remove walks upward and writes one below. The write never hits
	// an entry that is still to be read, so no forwarding is needed.
	always_comb begin
		wr_en   = 1'b0;
		cap_en  = 1'b0;
		wr_addr = ptr_s1;
		wr_data = rdata_s1;
		case (state_q) inside
			S_INS, S_INSW: begin
				wr_en   = vld_s1;
				wr_addr = ptr_s1 + IDX_W'(1);
			end
			S_INSV: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = val_q;
			end
			S_REM, S_REMW: begin
				if (vld_s1) begin
					if (ptr_s1 == pos_q) begin
						cap_en = 1'b1;
					end else begin
						wr_en   = 1'b1;
						wr_addr = ptr_s1 - IDX_W'(1);
					end
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= dec_next;
					end
				end
				S_INS: begin
					if (ptr_q == pos_q) begin
						state_q <= S_INSW;
					end
				end
				S_INSW: begin
					state_q <= S_INSV;
				end
				S_INSV: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_REM: begin
					if (ptr_q == last_q) begin
						state_q <= S_REMW;
					end
				end
				S_REMW: begin
					count_q <= count_q - CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold the result until the output register frees up
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pos_q        <= dec_pos;
			ptr_q        <= dec_ptr;
			last_q       <= dec_last;
			val_q        <= value_in;
			res_status_q <= dec_status;
			res_value_q  <= '0;
		end else if (state_q == S_INS) begin
			ptr_q <= ptr_q - IDX_W'(1);
		end else if (state_q == S_REM) begin
			ptr_q <= ptr_q + IDX_W'(1);
		end
		if (rd_en) begin
			ptr_s1 <= ptr_q;
		end
		if (cap_en) begin
			res_value_q <= rdata_s1;
		end
		if (out_load) begin
			value_out   <= res_value_q;
			status      <= res_status_q;
			count_after <= 9'(count_q);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/ilir_checker.sv -----
// Port checker for the indexed list block, bound to the top level.
// Depends on ilir_pkg; watches the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none
module ilir_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_valid,
	input wire                  in_ready,
	input ilir_pkg::op_t        operation,
	input ilir_pkg::pos_t       position,
	input ilir_pkg::word_t      value_in,
	input wire                  out_valid,
	input wire                  out_ready,
	input ilir_pkg::word_t      value_out,
	input ilir_pkg::status_t    status,
	input ilir_pkg::count_out_t count_after
);
	import ilir_pkg::*;

	count_out_t last_q;
	logic       seen_q;

	// Track the count reported by the last result taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			seen_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			last_q <= count_after;
			seen_q <= 1'b1;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(operation)
			&& $stable(position) && $stable(value_in))
		else $error("request changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_out)
			&& $stable(status) && $stable(count_after))
		else $error("result changed while stalled");

	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q && status != ST_OK |-> count_after == last_q)
		else $error("rejected request changed the count");

	a_ok_steps_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q && status == ST_OK |->
			count_after == last_q + 9'd1 || count_after == last_q - 9'd1)
		else $error("count moved by other than one");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> count_after == '0 && value_out == '0)
		else $error("empty status with a nonzero count or value");

endmodule

bind indexed_list_insert_remove_top ilir_checker u_ilir_checker (.*);
`default_nettype wire
